@@ rtl/core/lr3d_pkg.sv @@
`default_nettype none
package lr3d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ID_BITS        = 12;
  localparam int META_BITS      = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // action, starts, magnitudes, signs, axis, end, zero flag, material
  function automatic int entry_bits(input int coord_bits);
    return 7 * coord_bits + ID_BITS + META_BITS + 7;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/line_3d_rasterizer_top.sv @@
// 3-D line rasterizer: at most one point per accepted item, up to one item per cycle.
// Path from input accept to the point on the output port: input register at
// the accept edge, then setup queue, then step register.
// Throughput: one item per cycle while out_ready holds, bounded by the step unit.
// Reset (rst, synchronous): queue empty, no line active, no point pending.
`default_nettype none
module line_3d_rasterizer_top import lr3d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] z_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic signed [COORD_BITS-1:0] z_end,
  input  logic        [ID_BITS-1:0]    block_id,
  input  logic        [META_BITS-1:0]  block_meta,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic        [ID_BITS-1:0]    point_id,
  output logic        [META_BITS-1:0]  point_meta,
  output logic        [COORD_BITS:0]   points_so_far,
  output logic                         last
);

  localparam int ENTRY_BITS = entry_bits(COORD_BITS);

  logic                  push;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop;
  logic                  pop_valid;
  logic [ENTRY_BITS-1:0] pop_data;

  lr3d_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .x_start    (x_start),
    .y_start    (y_start),
    .z_start    (z_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .z_end      (z_end),
    .block_id   (block_id),
    .block_meta (block_meta),
    .q_push     (push),
    .q_ready    (push_ready),
    .q_entry    (push_data)
  );

  lr3d_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  lr3d_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (pop_valid),
    .q_pop         (pop),
    .q_entry       (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .point_id      (point_id),
    .point_meta    (point_meta),
    .points_so_far (points_so_far),
    .last          (last)
  );

endmodule
`default_nettype wire

@@ rtl/core/lr3d_front.sv @@
`default_nettype none
module lr3d_front import lr3d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENTRY_BITS = entry_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] z_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic signed [COORD_BITS-1:0] z_end,
  input  logic        [ID_BITS-1:0]    block_id,
  input  logic        [META_BITS-1:0]  block_meta,
  output logic                         q_push,
  input  logic                         q_ready,
  output logic        [ENTRY_BITS-1:0] q_entry
);

  logic                  a_valid;
  logic                  a_act;
  logic [COORD_BITS-1:0] a_st   [3];
  logic [COORD_BITS-1:0] a_end  [3];
  logic [COORD_BITS:0]   a_diff [3];
  logic [ID_BITS-1:0]    a_id;
  logic [META_BITS-1:0]  a_meta;

  logic [COORD_BITS-1:0] in_st  [3];
  logic [COORD_BITS-1:0] in_end [3];
  logic [COORD_BITS:0]   mag    [3];
  logic [COORD_BITS-1:0] ad     [3];
  logic                  neg    [3];
  axis_t                 dom;
  logic [COORD_BITS-1:0] endm;
  logic                  zero_len;

  assign in_st[0]  = x_start;
  assign in_st[1]  = y_start;
  assign in_st[2]  = z_start;
  assign in_end[0] = x_end;
  assign in_end[1] = y_end;
  assign in_end[2] = z_end;

  assign q_push   = a_valid && q_ready;
  assign in_ready = !a_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_act  <= action;
      a_id   <= block_id;
      a_meta <= block_meta;
      for (int i = 0; i < 3; i++) begin
        a_st[i]   <= in_st[i];
        a_end[i]  <= in_end[i];
        a_diff[i] <= {in_end[i][COORD_BITS-1], in_end[i]}
                   - {in_st[i][COORD_BITS-1], in_st[i]};
      end
    end
  end

  // |delta| always fits the coordinate width as an unsigned value
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = a_diff[i][COORD_BITS];
      mag[i] = neg[i] ? (~a_diff[i] + (COORD_BITS+1)'(1)) : a_diff[i];
      ad[i]  = mag[i][COORD_BITS-1:0];
    end
  end

  // x wins ties, then y
  always_comb begin
    if (ad[0] >= ad[1] && ad[0] >= ad[2]) begin
      dom = AXIS_X;
    end else if (ad[1] >= ad[2]) begin
      dom = AXIS_Y;
    end else begin
      dom = AXIS_Z;
    end
  end

  always_comb begin
    unique case (dom)
      AXIS_X:  begin endm = a_end[0]; zero_len = (ad[0] == '0); end
      AXIS_Y:  begin endm = a_end[1]; zero_len = (ad[1] == '0); end
      AXIS_Z:  begin endm = a_end[2]; zero_len = (ad[2] == '0); end
      default: begin endm = a_end[0]; zero_len = (ad[0] == '0); end
    endcase
  end

  assign q_entry = {a_act, a_st[0], a_st[1], a_st[2], ad[0], ad[1], ad[2],
                    neg[0], neg[1], neg[2], dom, endm, zero_len, a_id, a_meta};

endmodule
`default_nettype wire

@@ rtl/core/lr3d_queue.sv @@
`default_nettype none
module lr3d_queue import lr3d_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lr3d_back.sv @@
`default_nettype none
module lr3d_back import lr3d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENTRY_BITS = entry_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic        [ENTRY_BITS-1:0] q_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic        [ID_BITS-1:0]    point_id,
  output logic        [META_BITS-1:0]  point_meta,
  output logic        [COORD_BITS:0]   points_so_far,
  output logic                         last
);

  localparam int EW = COORD_BITS + 3;

  // queue entry fields
  logic                  e_act;
  logic [COORD_BITS-1:0] e_st  [3];
  logic [COORD_BITS-1:0] e_ad  [3];
  logic                  e_neg [3];
  logic [1:0]            e_dom_raw;
  axis_t                 e_dom;
  logic [COORD_BITS-1:0] e_endm;
  logic                  e_zero;
  logic [ID_BITS-1:0]    e_id;
  logic [META_BITS-1:0]  e_meta;

  // line state
  logic                  active;
  axis_t                 dom;
  logic [COORD_BITS-1:0] cur  [3];
  logic [COORD_BITS-1:0] endm;
  logic [COORD_BITS-1:0] ad   [3];
  logic                  neg  [3];
  logic [EW-1:0]         err  [3];
  logic [COORD_BITS:0]   cnt;
  logic [ID_BITS-1:0]    mat_id;
  logic [META_BITS-1:0]  mat_meta;

  logic [COORD_BITS-1:0] e_ad_dom;
  logic [EW-1:0]         err_init [3];
  logic [COORD_BITS-1:0] ad_dom;
  logic [EW-1:0]         ad2_dom;
  logic                  step     [3];
  logic [COORD_BITS-1:0] cur_next [3];
  logic [EW-1:0]         err_next [3];
  logic [COORD_BITS-1:0] cur_dom_next;
  logic                  hit_end;
  logic                  is_start;

  function automatic logic [COORD_BITS-1:0] e_neg_sel(input logic dn,
                                                      input logic [COORD_BITS-1:0] c);
    return dn ? (c - COORD_BITS'(1)) : (c + COORD_BITS'(1));
  endfunction

  assign {e_act, e_st[0], e_st[1], e_st[2], e_ad[0], e_ad[1], e_ad[2],
          e_neg[0], e_neg[1], e_neg[2], e_dom_raw, e_endm, e_zero,
          e_id, e_meta} = q_entry;
  assign e_dom = axis_t'(e_dom_raw);

  assign q_pop    = q_valid && (!out_valid || out_ready);
  assign is_start = (e_act == ACT_START);

  always_comb begin
    unique case (e_dom)
      AXIS_X:  e_ad_dom = e_ad[0];
      AXIS_Y:  e_ad_dom = e_ad[1];
      AXIS_Z:  e_ad_dom = e_ad[2];
      default: e_ad_dom = e_ad[0];
    endcase
  end

  always_comb begin
    unique case (dom)
      AXIS_X:  ad_dom = ad[0];
      AXIS_Y:  ad_dom = ad[1];
      AXIS_Z:  ad_dom = ad[2];
      default: ad_dom = ad[0];
    endcase
  end
  assign ad2_dom = {2'b00, ad_dom, 1'b0};

  // the dominant axis keeps an error slot too; it is never consulted
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      err_init[i] = {2'b00, e_ad[i], 1'b0} - {3'b000, e_ad_dom};
      step[i]     = (2'(i) == dom) || !err[i][EW-1];
      if (step[i]) begin
        cur_next[i] = e_neg_sel(neg[i], cur[i]);
      end else begin
        cur_next[i] = cur[i];
      end
      err_next[i] = err[i] + {2'b00, ad[i], 1'b0}
                  - (err[i][EW-1] ? {EW{1'b0}} : ad2_dom);
    end
  end

  always_comb begin
    unique case (dom)
      AXIS_X:  cur_dom_next = cur_next[0];
      AXIS_Y:  cur_dom_next = cur_next[1];
      AXIS_Z:  cur_dom_next = cur_next[2];
      default: cur_dom_next = cur_next[0];
    endcase
  end
  assign hit_end = (cur_dom_next == endm);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (q_pop) begin
      if (is_start) begin
        active    <= !e_zero;
        out_valid <= 1'b1;
      end else if (active) begin
        active    <= !hit_end;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (is_start) begin
        dom      <= e_dom;
        endm     <= e_endm;
        cnt      <= (COORD_BITS+1)'(1);
        last     <= e_zero;
        mat_id   <= e_id;
        mat_meta <= e_meta;
        for (int i = 0; i < 3; i++) begin
          cur[i] <= e_st[i];
          ad[i]  <= e_ad[i];
          neg[i] <= e_neg[i];
          err[i] <= err_init[i];
        end
      end else if (active) begin
        cnt  <= cnt + (COORD_BITS+1)'(1);
        last <= hit_end;
        for (int i = 0; i < 3; i++) begin
          cur[i] <= cur_next[i];
          err[i] <= err_next[i];
        end
      end
    end
  end

  assign point_x       = cur[0];
  assign point_y       = cur[1];
  assign point_z       = cur[2];
  assign point_id      = mat_id;
  assign point_meta    = mat_meta;
  assign points_so_far = cnt;

endmodule
`default_nettype wire

@@ rtl/core/lr3d_checker.sv @@
`default_nettype none
module lr3d_checker import lr3d_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic [COORD_BITS-1:0] point_z,
  input logic [COORD_BITS:0]   points_so_far,
  input logic                  last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(point_x) && $stable(point_y) && $stable(point_z) &&
      $stable(points_so_far) && $stable(last))
    else $error("output item changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> points_so_far != '0)
    else $error("point shown with zero count");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind line_3d_rasterizer_top lr3d_checker #(
  .COORD_BITS (COORD_BITS)
) u_lr3d_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .point_x       (point_x),
  .point_y       (point_y),
  .point_z       (point_z),
  .points_so_far (points_so_far),
  .last          (last)
);
`default_nettype wire

@@ tb/tb_line_3d_rasterizer_top.sv @@
`timescale 1ns / 1ps
module tb_line_3d_rasterizer_top;
  import lr3d_pkg::*;

  localparam int CB            = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_POINTS = 400;
  localparam int QUIET_FROM    = 330;
  localparam int MAX_PRINTED   = 50;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic        [CB+1:0] dbl_t;
  typedef logic signed [CB+2:0] err_t;
  typedef logic        [CB:0]   cnt_t;

  localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};

  typedef struct {
    logic                 action;
    coord_t               xs, ys, zs, xe, ye, ze;
    logic [ID_BITS-1:0]   id;
    logic [META_BITS-1:0] meta;
  } rast_item_t;

  typedef struct {
    coord_t               x, y, z;
    logic [ID_BITS-1:0]   id;
    logic [META_BITS-1:0] meta;
    cnt_t                 count;
    logic                 last;
  } point_t;

  typedef struct {
    rast_item_t item;
    int         reps;
    bit         typed;
    point_t     want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 action;
  coord_t               x_start, y_start, z_start, x_end, y_end, z_end;
  logic [ID_BITS-1:0]   block_id;
  logic [META_BITS-1:0] block_meta;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  coord_t               point_x, point_y, point_z;
  logic [ID_BITS-1:0]   point_id;
  logic [META_BITS-1:0] point_meta;
  cnt_t                 points_so_far;
  logic                 last;

  line_3d_rasterizer_top u_top (.*);

  // line walker state, mirrors the block
  logic                 ln_active;
  axis_t                major;
  coord_t               pos [3];
  coord_t               major_end;
  dbl_t                 dbl_delta [3];
  logic signed [1:0]    dir [3];
  err_t                 err [2];
  cnt_t                 n_points;
  logic [ID_BITS-1:0]   mat_id;
  logic [META_BITS-1:0] mat_meta;

  point_t expected_points [$];
  int     points_sent;
  int     points_seen;
  int     mismatches;
  int     cycles;
  int     stall_left = 0;
  bit     idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int minor_of(axis_t ax, int k);
    if (ax == AXIS_X) return (k == 0) ? 1 : 2;
    if (ax == AXIS_Y) return (k == 0) ? 0 : 2;
    return (k == 0) ? 0 : 1;
  endfunction

  task automatic walk_line(input rast_item_t it, output bit hit, output point_t pt);
    int     d;
    int     m;
    int     dom;
    coord_t st [3];
    coord_t en [3];
    hit = 1'b0;
    pt = '{default: '0};
    if (it.action == ACT_START) begin
      st[0] = it.xs; st[1] = it.ys; st[2] = it.zs;
      en[0] = it.xe; en[1] = it.ye; en[2] = it.ze;
      for (int i = 0; i < 3; i++) begin
        d = int'(en[i]) - int'(st[i]);
        dir[i] = (d > 0) ? 2'sd1 : ((d < 0) ? -2'sd1 : 2'sd0);
        dbl_delta[i] = dbl_t'(((d < 0) ? -d : d) * 2);
        pos[i] = st[i];
      end
      if (dbl_delta[0] >= dbl_delta[1] && dbl_delta[0] >= dbl_delta[2]) major = AXIS_X;
      else if (dbl_delta[1] >= dbl_delta[2]) major = AXIS_Y;
      else major = AXIS_Z;
      dom = int'(major);
      major_end = en[dom];
      for (int k = 0; k < 2; k++)
        err[k] = err_t'(int'(dbl_delta[minor_of(major, k)]) - int'(dbl_delta[dom] / 2));
      mat_id = it.id;
      mat_meta = it.meta;
      n_points = cnt_t'(1);
      ln_active = (pos[dom] != major_end);
      hit = 1'b1;
    end else if (ln_active) begin
      dom = int'(major);
      // minor axes step first, then the dominant axis
      for (int k = 0; k < 2; k++) begin
        m = minor_of(major, k);
        if (err[k] >= 0) begin
          pos[m] = coord_t'(int'(pos[m]) + int'(dir[m]));
          err[k] = err_t'(int'(err[k]) - int'(dbl_delta[dom]));
        end
      end
      pos[dom] = coord_t'(int'(pos[dom]) + int'(dir[dom]));
      for (int k = 0; k < 2; k++)
        err[k] = err_t'(int'(err[k]) + int'(dbl_delta[minor_of(major, k)]));
      n_points = n_points + 1'b1;
      ln_active = (pos[dom] != major_end);
      hit = 1'b1;
    end
    if (hit) pt = '{pos[0], pos[1], pos[2], mat_id, mat_meta, n_points, !ln_active};
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR point %0d: %s", points_seen, msg);
  endtask

  task automatic rand_payload(output rast_item_t it);
    it.action = 1'($urandom);
    it.xs = coord_t'($urandom);
    it.ys = coord_t'($urandom);
    it.zs = coord_t'($urandom);
    it.xe = coord_t'($urandom);
    it.ye = coord_t'($urandom);
    it.ze = coord_t'($urandom);
    it.id = ID_BITS'($urandom);
    it.meta = META_BITS'($urandom);
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_item(input rast_item_t it, input bit typed, input point_t want);
    bit     hit;
    point_t pt;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= it.action;
    x_start    <= it.xs;
    y_start    <= it.ys;
    z_start    <= it.zs;
    x_end      <= it.xe;
    y_end      <= it.ye;
    z_end      <= it.ze;
    block_id   <= it.id;
    block_meta <= it.meta;
    do @(posedge clk); while (!in_ready);
    walk_line(it, hit, pt);
    if (hit) begin
      expected_points.push_back(typed ? want : pt);
      points_sent++;
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("point (%0d,%0d,%0d) with none expected",
                                point_x, point_y, point_z));
      end else begin
        w = expected_points.pop_front();
        if (point_x !== w.x)
          flag_mismatch($sformatf("point_x got %0d want %0d", point_x, w.x));
        if (point_y !== w.y)
          flag_mismatch($sformatf("point_y got %0d want %0d", point_y, w.y));
        if (point_z !== w.z)
          flag_mismatch($sformatf("point_z got %0d want %0d", point_z, w.z));
        if (point_id !== w.id)
          flag_mismatch($sformatf("point_id got %0h want %0h", point_id, w.id));
        if (point_meta !== w.meta)
          flag_mismatch($sformatf("point_meta got %0h want %0h", point_meta, w.meta));
        if (points_so_far !== w.count)
          flag_mismatch($sformatf("points_so_far got %0d want %0d", points_so_far, w.count));
        if (last !== w.last)
          flag_mismatch($sformatf("last got %0b want %0b", last, w.last));
      end
      points_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t  rows [$];
    rast_item_t it;
    rast_item_t nx;
    point_t     no_pt;
    coord_t     sv [3];
    coord_t     ev [3];
    int         kind;
    int         d;
    int         e;
    int         len;
    int         n_next;

    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_START;
    x_start = '0; y_start = '0; z_start = '0;
    x_end = '0; y_end = '0; z_end = '0;
    block_id = '0;
    block_meta = '0;
    ln_active = 1'b0;
    major = AXIS_X;
    major_end = '0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = '0;
      dbl_delta[i] = '0;
      dir[i] = '0;
    end
    err[0] = '0;
    err[1] = '0;
    n_points = '0;
    mat_id = '0;
    mat_meta = '0;
    points_sent = 0;
    points_seen = 0;
    mismatches = 0;
    cycles = 0;

    no_pt = '{default: '0};
    nx = '{default: '0};
    nx.action = ACT_NEXT;

    // next right after reset: no line, nothing comes out
    rows.push_back('{nx, 1, 1'b0, no_pt});
    // zero-length line: one point, last set, line not kept
    rows.push_back('{'{ACT_START, coord_t'(0), coord_t'(0), coord_t'(0),
                       coord_t'(0), coord_t'(0), coord_t'(0), '1, '1}, 1, 1'b1,
                     '{coord_t'(0), coord_t'(0), coord_t'(0), '1, '1, cnt_t'(1), 1'b1}});
    rows.push_back('{nx, 1, 1'b0, no_pt});
    // full-range diagonal, x wins the three-way tie
    rows.push_back('{'{ACT_START, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0, '0}, 1, 1'b1,
                     '{C_MIN, C_MIN, C_MIN, '0, '0, cnt_t'(1), 1'b0}});
    rows.push_back('{nx, 2, 1'b0, no_pt});
    // start on top of an active line drops the old one
    rows.push_back('{'{ACT_START, C_MAX, coord_t'(0), C_MIN, C_MIN, coord_t'(5), C_MAX,
                       12'hABC, 4'h5}, 1, 1'b1,
                     '{C_MAX, coord_t'(0), C_MIN, 12'hABC, 4'h5, cnt_t'(1), 1'b0}});
    rows.push_back('{nx, 2, 1'b0, no_pt});
    // y dominant, run past the end
    rows.push_back('{'{ACT_START, coord_t'(0), coord_t'(0), coord_t'(0),
                       coord_t'(2), coord_t'(3), coord_t'(-1), 12'h001, 4'h1}, 1, 1'b0, no_pt});
    rows.push_back('{nx, 4, 1'b0, no_pt});
    // z dominant, negative direction
    rows.push_back('{'{ACT_START, coord_t'(5), coord_t'(-5), coord_t'(0),
                       coord_t'(4), coord_t'(-4), coord_t'(-3), 12'h555, 4'hA}, 1, 1'b0, no_pt});
    rows.push_back('{nx, 3, 1'b0, no_pt});
    // y beats z on a tie
    rows.push_back('{'{ACT_START, coord_t'(0), coord_t'(0), coord_t'(0),
                       coord_t'(1), coord_t'(2), coord_t'(2), 12'h7FF, 4'h7}, 1, 1'b0, no_pt});
    rows.push_back('{nx, 2, 1'b0, no_pt});
    rows.push_back('{'{ACT_START, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 12'h800, 4'h8}, 1,
                     1'b1, '{C_MAX, C_MIN, C_MAX, 12'h800, 4'h8, cnt_t'(1), 1'b1}});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r])
      for (int n = 0; n < rows[r].reps; n++) push_item(rows[r].item, rows[r].typed, rows[r].want);

    points_sent = 0;
    while (points_sent < RANDOM_POINTS) begin
      idle_en = (points_sent < QUIET_FROM);
      rand_payload(it);
      it.action = ACT_START;
      kind = $urandom_range(0, 9);
      sv[0] = it.xs; sv[1] = it.ys; sv[2] = it.zs;
      len = 0;
      for (int i = 0; i < 3; i++) begin
        if (kind < 7) begin
          if ($urandom_range(0, 3) == 0) d = int'($urandom_range(0, 80)) - 40;
          else d = int'($urandom_range(0, 16)) - 8;
          e = int'(sv[i]) + d;
          if (e > int'(C_MAX)) e = int'(C_MAX);
          if (e < int'(C_MIN)) e = int'(C_MIN);
          ev[i] = coord_t'(e);
          d = e - int'(sv[i]);
          if (d < 0) d = -d;
          if (d > len) len = d;
        end else if (kind < 9) begin
          ev[i] = coord_t'($urandom);
        end else begin
          ev[i] = sv[i];
        end
      end
      it.xe = ev[0]; it.ye = ev[1]; it.ze = ev[2];
      if (kind < 7) begin
        // mostly full lines with a little overrun, some cut short by a new start
        if ($urandom_range(0, 4) == 0) n_next = $urandom_range(0, len);
        else n_next = len + $urandom_range(0, 2);
      end else if (kind < 9) begin
        n_next = $urandom_range(0, 24);
      end else begin
        n_next = $urandom_range(0, 1);
      end
      push_item(it, 1'b0, no_pt);
      for (int j = 0; j < n_next; j++) begin
        rand_payload(it);
        it.action = ACT_NEXT;
        push_item(it, 1'b0, no_pt);
      end
    end

    idle_en = 1'b0;
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
